[sv/assert_macros.svh]
// Assertion macros used by the checker file.
// Each macro expects clk and rst_n to exist in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define AMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define AMT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define AMT_ASSERT_ALWAYS_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/amt_pkg.sv]
// Package for the amicable number test: field widths, limits, state types.
// No dependencies.
`timescale 1ns / 1ps

package amt_pkg;

  localparam int NUMBER_BITS_DEF = 14;
  localparam int DSUM_BITS       = 16;
  localparam int PSUM_BITS       = 18;

  localparam logic [DSUM_BITS-1:0] DSUM_MAX = '1;
  localparam logic [PSUM_BITS-1:0] PSUM_MAX = '1;

  typedef enum logic [1:0] {
    T_IDLE,
    T_PASS1,
    T_PASS2,
    T_HOLD
  } amt_top_state_t;

  typedef enum logic [1:0] {
    AQ_IDLE,
    AQ_ISSUE,
    AQ_WAIT
  } amt_aliq_state_t;

endpackage

[sv/amt_if.sv]
// Valid/ready stream interfaces for the input number and the result item.
// Depends on amt_pkg.
`timescale 1ns / 1ps

interface amt_in_if #(parameter int NUMBER_BITS = amt_pkg::NUMBER_BITS_DEF);
  logic                   valid;
  logic                   ready;
  logic [NUMBER_BITS-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink   (input valid, input number, output ready);
endinterface

interface amt_out_if;
  logic                           valid;
  logic                           ready;
  logic [amt_pkg::DSUM_BITS-1:0]  divisor_sum;
  logic [amt_pkg::PSUM_BITS-1:0]  partner_divisor_sum;
  logic                           is_amicable;

  modport source (output valid, output divisor_sum, output partner_divisor_sum,
                  output is_amicable, input ready);
  modport sink   (input valid, input divisor_sum, input partner_divisor_sum,
                  input is_amicable, output ready);
endinterface

[sv/amt_div.sv]
// Restoring divider, one quotient bit per cycle; done rises once the last quotient bit is shifted in.
// Depends on amt_pkg for the default width.
`timescale 1ns / 1ps

module amt_div #(
  parameter int W = amt_pkg::DSUM_BITS
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rem
);

  localparam int CW = $clog2(W + 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W:0]    rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dvs_r, dvs_nxt;

  logic [W:0]    shifted;
  logic [W+1:0]  diff;

  always_comb begin
    shifted  = {rem_r[W-1:0], quo_r[W-1]};
    diff     = {1'b0, shifted} - {2'b00, dvs_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(W);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      // keep the trial difference only when it did not go negative
      rem_nxt = diff[W+1] ? shifted : diff[W:0];
      quo_nxt = {quo_r[W-2:0], ~diff[W+1]};
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = quo_r;
  assign rem  = rem_r[W-1:0];

endmodule

[sv/amt_aliq.sv]
// Aliquot sum sequencer: trial division d = 1, 2, ... while n / d >= d,
// pairing d with n / d. Depends on amt_pkg and amt_div.
`timescale 1ns / 1ps

module amt_aliq #(
  parameter int NW = amt_pkg::DSUM_BITS,
  parameter int AW = amt_pkg::DSUM_BITS + 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] n,
  output logic          done,
  output logic [AW-1:0] sum
);

  import amt_pkg::*;

  amt_aliq_state_t state_r, state_nxt;
  logic [NW-1:0]   n_r, n_nxt;
  logic [NW-1:0]   d_r, d_nxt;
  logic [AW-1:0]   total_r, total_nxt;
  logic [AW-1:0]   sum_r, sum_nxt;
  logic            done_r, done_nxt;

  logic            div_start;
  logic            div_done;
  logic [NW-1:0]   div_q;
  logic [NW-1:0]   div_rem;
  logic            n_small;
  logic            past_root;

  amt_div #(.W(NW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (n_r),
    .divisor  (d_r),
    .done     (div_done),
    .quot     (div_q),
    .rem      (div_rem)
  );

  assign n_small   = (n[NW-1:1] == '0);
  // n / d < d is the same test as d * d > n
  assign past_root = (div_q < d_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      AQ_IDLE:  if (start && !n_small) state_nxt = AQ_ISSUE;
      AQ_ISSUE: state_nxt = AQ_WAIT;
      AQ_WAIT: begin
        if (div_done) state_nxt = past_root ? AQ_IDLE : AQ_ISSUE;
      end
      default:  state_nxt = AQ_IDLE;
    endcase
  end

  always_comb begin
    div_start = (state_r == AQ_ISSUE);
    n_nxt     = n_r;
    d_nxt     = d_r;
    total_nxt = total_r;
    sum_nxt   = sum_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      AQ_IDLE: begin
        if (start) begin
          n_nxt     = n;
          d_nxt     = NW'(1);
          total_nxt = '0;
          if (n_small) begin
            sum_nxt  = '0;
            done_nxt = 1'b1;
          end
        end
      end
      AQ_WAIT: begin
        if (div_done) begin
          if (past_root) begin
            sum_nxt  = total_r - AW'(n_r);
            done_nxt = 1'b1;
          end else begin
            if (div_rem == '0) begin
              total_nxt = total_r + AW'(d_r) + ((div_q != d_r) ? AW'(div_q) : '0);
            end
            d_nxt = d_r + NW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AQ_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    d_r     <= d_nxt;
    total_r <= total_nxt;
    sum_r   <= sum_nxt;
  end

  assign done = done_r;
  assign sum  = sum_r;

endmodule

[sv/amicable_number_test.sv]
// Top level of the amicable number test: two aliquot-sum passes on one
// shared divider sequencer. Depends on amt_pkg, amt_if, amt_aliq, amt_div.
//
//  channel  dir  handshake            payload
//  in_ch    in   valid/ready          number [NUMBER_BITS]
//  out_ch   out  valid/ready          divisor_sum [16], partner_divisor_sum [18],
//                                     is_amicable [1]
//
// W = max(NUMBER_BITS, 16) is the divider length. The bit-serial divider is reused
// for every trial divisor of both passes.
// in_ch.ready is high only between items; a finished result waits in the
// output register, and the next item is taken while it waits.
// Reset (synchronous, active low) clears the sequencers and out_ch.valid.
`timescale 1ns / 1ps

module amicable_number_test #(
  parameter int NUMBER_BITS = amt_pkg::NUMBER_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  amt_in_if.sink    in_ch,
  amt_out_if.source out_ch
);

  import amt_pkg::*;

  localparam int NW = (NUMBER_BITS > DSUM_BITS) ? NUMBER_BITS : DSUM_BITS;
  localparam int AW = NW + 4;
  localparam int CW = (NUMBER_BITS > PSUM_BITS) ? NUMBER_BITS : PSUM_BITS;

  amt_top_state_t         state_r, state_nxt;
  logic [NUMBER_BITS-1:0] a_r;
  logic [DSUM_BITS-1:0]   b_r;
  logic [PSUM_BITS-1:0]   x_r;
  logic                   out_valid_r;
  logic [DSUM_BITS-1:0]   out_dsum_r;
  logic [PSUM_BITS-1:0]   out_psum_r;
  logic                   out_amic_r;

  logic                   aq_start;
  logic [NW-1:0]          aq_n;
  logic                   aq_done;
  logic [AW-1:0]          aq_sum;
  logic [DSUM_BITS-1:0]   b_sat;
  logic [PSUM_BITS-1:0]   x_sat;
  logic                   accept;
  logic                   load_out;
  logic                   amic;

  amt_aliq #(.NW(NW), .AW(AW)) u_aliq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (aq_start),
    .n     (aq_n),
    .done  (aq_done),
    .sum   (aq_sum)
  );

  assign b_sat = (aq_sum > AW'(DSUM_MAX)) ? DSUM_MAX : aq_sum[DSUM_BITS-1:0];
  assign x_sat = (aq_sum > AW'(PSUM_MAX)) ? PSUM_MAX : aq_sum[PSUM_BITS-1:0];
  assign amic  = (CW'(x_r) == CW'(a_r)) && (NW'(a_r) != NW'(b_r));

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      T_IDLE:  if (in_ch.valid) state_nxt = T_PASS1;
      T_PASS1: if (aq_done) state_nxt = T_PASS2;
      T_PASS2: if (aq_done) state_nxt = T_HOLD;
      T_HOLD:  if (!out_valid_r || out_ch.ready) state_nxt = T_IDLE;
      default: state_nxt = T_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == T_IDLE);
    accept      = (state_r == T_IDLE) && in_ch.valid;
    load_out    = (state_r == T_HOLD) && (!out_valid_r || out_ch.ready);
    // second pass starts in the same cycle the first one finishes
    aq_start    = accept || ((state_r == T_PASS1) && aq_done);
    aq_n        = (state_r == T_PASS1) ? NW'(b_sat) : NW'(in_ch.number);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) a_r <= in_ch.number;
    if ((state_r == T_PASS1) && aq_done) b_r <= b_sat;
    if ((state_r == T_PASS2) && aq_done) x_r <= x_sat;
    if (load_out) begin
      out_dsum_r <= b_r;
      out_psum_r <= x_r;
      out_amic_r <= amic;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.divisor_sum         = out_dsum_r;
  assign out_ch.partner_divisor_sum = out_psum_r;
  assign out_ch.is_amicable         = out_amic_r;

endmodule

[sv/amt_checker.sv]
// Port-level checker for amicable_number_test, attached by bind.
// Depends on amt_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module amt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [amt_pkg::DSUM_BITS-1:0] out_divisor_sum,
  input logic [amt_pkg::PSUM_BITS-1:0] out_partner_divisor_sum,
  input logic                          out_is_amicable
);

  import amt_pkg::*;

  // a result waiting on the sink stays offered
  `AMT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // one item at a time: no second item right after an accept
  `AMT_ASSERT_NXT(a_busy, in_valid && in_ready, !in_ready, "input ready while busy")

  // a zero sum has a zero sum of its own
  `AMT_ASSERT_IMP(a_zero_sum, out_valid && (out_divisor_sum == '0),
                  out_partner_divisor_sum == '0, "nonzero partner sum of zero")

  // an amicable pair needs both sums at least two
  `AMT_ASSERT_IMP(a_amic_sums, out_valid && out_is_amicable,
                  (out_divisor_sum > DSUM_BITS'(1)) && (out_partner_divisor_sum > PSUM_BITS'(1)),
                  "amicable flag with trivial sums")

  `AMT_ASSERT_ALWAYS_NXT(a_reset, !rst_n, !out_valid, "result valid after reset")

endmodule

bind amicable_number_test amt_checker u_amt_checker (
  .clk                     (clk),
  .rst_n                   (rst_n),
  .in_valid                (in_ch.valid),
  .in_ready                (in_ch.ready),
  .out_valid               (out_ch.valid),
  .out_ready               (out_ch.ready),
  .out_divisor_sum         (out_ch.divisor_sum),
  .out_partner_divisor_sum (out_ch.partner_divisor_sum),
  .out_is_amicable         (out_ch.is_amicable)
);
